### sv/arpc_pkg.sv
`default_nettype none
package arpc_pkg;
	// Table sizes and interface width.
	localparam int CACHE_DEPTH = 32;
	localparam int REQ_DEPTH   = 16;
	localparam int IFACE_BITS  = 4;
	localparam int E_IDX_W     = $clog2(CACHE_DEPTH);
	localparam int R_IDX_W     = $clog2(REQ_DEPTH);
	localparam int IDX_W       = (E_IDX_W > R_IDX_W) ? E_IDX_W : R_IDX_W;

	// Field widths.
	localparam int OP_W   = 3;
	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int AGE_W  = 16;
	localparam int SEND_W = 8;
	localparam int CFG_W  = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_QUEUE  = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_TIMEOUT   = 1'b0;
	localparam logic CFG_MAX_SENDS = 1'b1;

	// Result formats selected by the controller.
	localparam logic [2:0] RES_PLAIN  = 3'd0;
	localparam logic [2:0] RES_LOOKUP = 3'd1;
	localparam logic [2:0] RES_INSERT = 3'd2;
	localparam logic [2:0] RES_QUEUE  = 3'd3;
	localparam logic [2:0] RES_TICK   = 3'd4;

	typedef struct packed {
		logic       load;
		logic       idx_clr;
		logic       idx_inc;
		logic       emit;
		logic [2:0] res_sel;
		logic       age;
		logic       wr_entry;
		logic       req_alloc;
		logic       rm_req;
		logic       tick_upd;
		logic       clear;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            e_match;
		logic            e_last;
		logic            r_match;
		logic            r_last;
		logic            r_any;
		logic            r_cur;
		logic            r_more;
		logic            out_free;
	} sts_t;
endpackage
`default_nettype wire

### sv/arpc_datapath.sv
`default_nettype none
module arpc_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire arpc_pkg::cmd_t                      cmd,
	output      arpc_pkg::sts_t                      sts,
	input  wire logic [arpc_pkg::OP_W-1:0]           operation,
	input  wire logic [arpc_pkg::IP_W-1:0]           ip,
	input  wire logic [arpc_pkg::MAC_W-1:0]          mac,
	input  wire logic [arpc_pkg::IFACE_BITS-1:0]     iface,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_index,
	input  wire logic [arpc_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                out_stall,
	output      logic                                out_valid,
	output      logic                                hit,
	output      logic [arpc_pkg::MAC_W-1:0]          mac_out,
	output      logic                                request_found,
	output      logic                                send_request,
	output      logic                                drop_request,
	output      logic [arpc_pkg::IP_W-1:0]           request_ip,
	output      logic [arpc_pkg::IFACE_BITS-1:0]     send_iface,
	output      logic                                full_res,
	output      logic                                last
);
	// Latched transaction and configuration.
	logic [arpc_pkg::OP_W-1:0]       op_q;
	logic [arpc_pkg::IP_W-1:0]       ip_q;
	logic [arpc_pkg::MAC_W-1:0]      mac_q;
	logic [arpc_pkg::IFACE_BITS-1:0] iface_q;
	logic [arpc_pkg::AGE_W-1:0]      timeout_q;
	logic [arpc_pkg::SEND_W-1:0]     max_sends_q;

	// Entry and request tables.
	logic [arpc_pkg::IP_W-1:0]       e_addr_q [arpc_pkg::CACHE_DEPTH];
	logic [arpc_pkg::MAC_W-1:0]      e_mac_q  [arpc_pkg::CACHE_DEPTH];
	logic [arpc_pkg::AGE_W-1:0]      e_age_q  [arpc_pkg::CACHE_DEPTH];
	logic [arpc_pkg::CACHE_DEPTH-1:0] e_valid_q;
	logic [arpc_pkg::IP_W-1:0]       r_addr_q  [arpc_pkg::REQ_DEPTH];
	logic [arpc_pkg::SEND_W-1:0]     r_sends_q [arpc_pkg::REQ_DEPTH];
	logic [arpc_pkg::IFACE_BITS-1:0] r_port_q  [arpc_pkg::REQ_DEPTH];
	logic [arpc_pkg::REQ_DEPTH-1:0]  r_active_q;

	logic [arpc_pkg::IDX_W-1:0]      idx_q;
	logic                            out_valid_q;

	logic [arpc_pkg::E_IDX_W-1:0] e_idx;
	logic [arpc_pkg::R_IDX_W-1:0] r_idx;
	logic                         e_match;
	logic                         r_match;
	logic                         e_free_any;
	logic [arpc_pkg::E_IDX_W-1:0] e_free_slot;
	logic                         r_free_any;
	logic [arpc_pkg::R_IDX_W-1:0] r_free_slot;
	logic                         r_more;
	logic                         r_drop;
	logic                         out_free;

	logic                            res_hit;
	logic [arpc_pkg::MAC_W-1:0]      res_mac;
	logic                            res_rfound;
	logic                            res_send;
	logic                            res_drop;
	logic [arpc_pkg::IP_W-1:0]       res_rip;
	logic [arpc_pkg::IFACE_BITS-1:0] res_siface;
	logic                            res_full;
	logic                            res_last;

	// Compare the slot under the scan index.
	assign e_idx   = idx_q[arpc_pkg::E_IDX_W-1:0];
	assign r_idx   = idx_q[arpc_pkg::R_IDX_W-1:0];
	assign e_match = e_valid_q[e_idx] && (e_addr_q[e_idx] == ip_q);
	assign r_match = r_active_q[r_idx] && (r_addr_q[r_idx] == ip_q);
	assign r_drop  = r_sends_q[r_idx] >= max_sends_q;
	assign out_free = !out_valid_q || !out_stall;

	// Lowest free slots and whether active requests remain past the index.
	always_comb begin
		e_free_any  = 1'b0;
		e_free_slot = '0;
		for (int i = arpc_pkg::CACHE_DEPTH - 1; i >= 0; i--) begin
			if (!e_valid_q[i]) begin
				e_free_any  = 1'b1;
				e_free_slot = arpc_pkg::E_IDX_W'(i);
			end
		end
		r_free_any  = 1'b0;
		r_free_slot = '0;
		r_more      = 1'b0;
		for (int i = arpc_pkg::REQ_DEPTH - 1; i >= 0; i--) begin
			if (!r_active_q[i]) begin
				r_free_any  = 1'b1;
				r_free_slot = arpc_pkg::R_IDX_W'(i);
			end
			if (r_active_q[i] && (arpc_pkg::R_IDX_W'(i) > r_idx)) begin
				r_more = 1'b1;
			end
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.op       = op_q;
		sts.e_match  = e_match;
		sts.e_last   = e_idx == arpc_pkg::E_IDX_W'(arpc_pkg::CACHE_DEPTH - 1);
		sts.r_match  = r_match;
		sts.r_last   = r_idx == arpc_pkg::R_IDX_W'(arpc_pkg::REQ_DEPTH - 1);
		sts.r_any    = |r_active_q;
		sts.r_cur    = r_active_q[r_idx];
		sts.r_more   = r_more;
		sts.out_free = out_free;
	end

	// Result formatting.
	always_comb begin
		res_hit    = 1'b0;
		res_mac    = '0;
		res_rfound = 1'b0;
		res_send   = 1'b0;
		res_drop   = 1'b0;
		res_rip    = '0;
		res_siface = '0;
		res_full   = 1'b0;
		res_last   = 1'b1;
		case (cmd.res_sel)
			arpc_pkg::RES_LOOKUP: begin
				res_hit = e_match;
				res_mac = e_match ? e_mac_q[e_idx] : '0;
			end
			arpc_pkg::RES_INSERT: begin
				res_rfound = r_match;
				res_full   = !e_free_any;
			end
			arpc_pkg::RES_QUEUE: begin
				res_full = !r_match && !r_free_any;
			end
			arpc_pkg::RES_TICK: begin
				res_rip  = r_addr_q[r_idx];
				res_drop = r_drop;
				res_send = !r_drop;
				res_siface = r_drop ? '0 : r_port_q[r_idx];
				res_last = !r_more;
			end
			default: begin
				res_last = 1'b1;
			end
		endcase
	end

	// Control registers: configuration, scan index, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= arpc_pkg::AGE_W'(30);
			max_sends_q <= arpc_pkg::SEND_W'(5);
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == arpc_pkg::CFG_TIMEOUT) begin
					timeout_q <= cfg_data;
				end else begin
					max_sends_q <= cfg_data[arpc_pkg::SEND_W-1:0];
				end
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Valid bits, ages, active bits and send counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_valid_q  <= '0;
			r_active_q <= '0;
			for (int i = 0; i < arpc_pkg::CACHE_DEPTH; i++) begin
				e_age_q[i] <= '0;
			end
			for (int i = 0; i < arpc_pkg::REQ_DEPTH; i++) begin
				r_sends_q[i] <= '0;
			end
		end else begin
			if (cmd.age) begin
				for (int i = 0; i < arpc_pkg::CACHE_DEPTH; i++) begin
					if (e_valid_q[i]) begin
						if (e_age_q[i] != '1) begin
							e_age_q[i] <= e_age_q[i] + 1'b1;
							if ((e_age_q[i] + 1'b1) > timeout_q) begin
								e_valid_q[i] <= 1'b0;
							end
						end else if (e_age_q[i] > timeout_q) begin
							e_valid_q[i] <= 1'b0;
						end
					end
				end
			end
			if (cmd.wr_entry && e_free_any) begin
				e_valid_q[e_free_slot] <= 1'b1;
				e_age_q[e_free_slot]   <= '0;
			end
			if (cmd.req_alloc && !r_match && r_free_any) begin
				r_active_q[r_free_slot] <= 1'b1;
				r_sends_q[r_free_slot]  <= '0;
			end
			if (cmd.rm_req && r_match) begin
				r_active_q[r_idx] <= 1'b0;
			end
			if (cmd.tick_upd) begin
				if (r_drop) begin
					r_active_q[r_idx] <= 1'b0;
				end else begin
					r_sends_q[r_idx] <= r_sends_q[r_idx] + 1'b1;
				end
			end
			if (cmd.clear) begin
				e_valid_q  <= '0;
				r_active_q <= '0;
			end
		end
	end

	// Payload registers: transaction, table contents, result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			ip_q    <= ip;
			mac_q   <= mac;
			iface_q <= iface;
		end
		if (cmd.wr_entry && e_free_any) begin
			e_addr_q[e_free_slot] <= ip_q;
			e_mac_q[e_free_slot]  <= mac_q;
		end
		if (cmd.req_alloc && !r_match && r_free_any) begin
			r_addr_q[r_free_slot] <= ip_q;
			r_port_q[r_free_slot] <= iface_q;
		end
		if (cmd.emit) begin
			hit           <= res_hit;
			mac_out       <= res_mac;
			request_found <= res_rfound;
			send_request  <= res_send;
			drop_request  <= res_drop;
			request_ip    <= res_rip;
			send_iface    <= res_siface;
			full_res      <= res_full;
			last          <= res_last;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

### sv/arpc_ctrl.sv
`default_nettype none
module arpc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_stall,
	input  wire arpc_pkg::sts_t sts,
	output      arpc_pkg::cmd_t cmd
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DISP   = 3'd1;
	localparam logic [2:0] S_SCAN_E = 3'd2;
	localparam logic [2:0] S_SCAN_R = 3'd3;
	localparam logic [2:0] S_AGE    = 3'd4;
	localparam logic [2:0] S_TICK   = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_stall = state_q != S_IDLE;

	// Next state and datapath commands.
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					state_nxt   = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op) inside
					arpc_pkg::OP_LOOKUP: state_nxt = S_SCAN_E;
					arpc_pkg::OP_INSERT, arpc_pkg::OP_QUEUE, arpc_pkg::OP_REMOVE:
						state_nxt = S_SCAN_R;
					arpc_pkg::OP_TICK: state_nxt = S_AGE;
					default: state_nxt = S_DONE;
				endcase
			end
			S_SCAN_E: begin
				if (sts.e_match || sts.e_last) begin
					if (sts.out_free) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = arpc_pkg::RES_LOOKUP;
						state_nxt   = S_IDLE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SCAN_R: begin
				if (sts.r_match || sts.r_last) begin
					if (sts.out_free) begin
						cmd.emit  = 1'b1;
						state_nxt = S_IDLE;
						unique case (sts.op) inside
							arpc_pkg::OP_INSERT: begin
								cmd.res_sel  = arpc_pkg::RES_INSERT;
								cmd.wr_entry = 1'b1;
							end
							arpc_pkg::OP_QUEUE: begin
								cmd.res_sel   = arpc_pkg::RES_QUEUE;
								cmd.req_alloc = 1'b1;
							end
							default: begin
								cmd.res_sel = arpc_pkg::RES_PLAIN;
								cmd.rm_req  = 1'b1;
							end
						endcase
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_AGE: begin
				cmd.age   = 1'b1;
				state_nxt = sts.r_any ? S_TICK : S_DONE;
			end
			S_TICK: begin
				if (sts.r_cur) begin
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.res_sel  = arpc_pkg::RES_TICK;
						cmd.tick_upd = 1'b1;
						if (sts.r_more) begin
							cmd.idx_inc = 1'b1;
						end else begin
							state_nxt = S_IDLE;
						end
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = arpc_pkg::RES_PLAIN;
					cmd.clear   = sts.op == arpc_pkg::OP_CLEAR;
					state_nxt   = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule
`default_nettype wire

### sv/arp_cache_with_request_retry.sv
`default_nettype none
// ARP cache with request retry: a table of IPv4-to-MAC entries and a table of
// pending resolution requests, one transaction at a time. A compare unit checks
// one table slot per cycle: a lookup scans the entry table, an insert, queue or
// remove scans the request table, and a tick ages the entries and then walks the
// request slots up to the last active one; clear or an unused code scans nothing.
// Every operation waits while the output is stalled. A tick gives one result per
// active request in slot order, with last on the final one, or one result when no
// request is active; every other operation gives one.
module arp_cache_with_request_retry (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire logic [arpc_pkg::OP_W-1:0]       operation,
	input  wire logic [arpc_pkg::IP_W-1:0]       ip,
	input  wire logic [arpc_pkg::MAC_W-1:0]      mac,
	input  wire logic [arpc_pkg::IFACE_BITS-1:0] iface,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [arpc_pkg::CFG_W-1:0]      cfg_data,
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      logic                            hit,
	output      logic [arpc_pkg::MAC_W-1:0]      mac_out,
	output      logic                            request_found,
	output      logic                            send_request,
	output      logic                            drop_request,
	output      logic [arpc_pkg::IP_W-1:0]       request_ip,
	output      logic [arpc_pkg::IFACE_BITS-1:0] send_iface,
	output      logic                            full_res,
	output      logic                            last
);
	arpc_pkg::cmd_t cmd;
	arpc_pkg::sts_t sts;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	arpc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.ip            (ip),
		.mac           (mac),
		.iface         (iface),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.hit           (hit),
		.mac_out       (mac_out),
		.request_found (request_found),
		.send_request  (send_request),
		.drop_request  (drop_request),
		.request_ip    (request_ip),
		.send_iface    (send_iface),
		.full_res      (full_res),
		.last          (last)
	);

`ifndef ASSERT_OFF
	// An accepted transaction keeps the input side busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	// A result that is not the final one means the tick walk is still running.
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> in_stall)
		else $error("non-final result while idle");

	// A lookup hit never carries tick or full flags.
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (!send_request && !drop_request && !full_res && last))
		else $error("lookup hit mixed with other result fields");
`endif
endmodule
`default_nettype wire
